// ===== hw/rtl/vpad_pkg.sv =====
// Shared types and constants of the vector polar angle pipeline.
package vpad_pkg;

   localparam int DATA_W  = 64;
   localparam int Z_W     = 26;
   localparam int ANGLE_W = 25;
   localparam int ATAN_W  = 22;

   localparam logic signed [Z_W-1:0] DEG_90   = Z_W'(90 * 65536);
   localparam logic signed [Z_W-1:0] DEG_180  = Z_W'(180 * 65536);
   localparam logic signed [Z_W-1:0] DEG_270  = Z_W'(270 * 65536);
   localparam logic signed [Z_W-1:0] DEG_FULL = Z_W'(360 * 65536);

   // atan(2^-i) in 1/65536 degree, rounded to nearest.
   localparam logic [ATAN_W-1:0] ATAN_TABLE [32] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
      22'd234379,  22'd117304,  22'd58666,  22'd29335,
      22'd14668,   22'd7334,    22'd3667,   22'd1833,
      22'd917,     22'd458,     22'd229,    22'd115,
      22'd57,      22'd29,      22'd14,     22'd7,
      22'd4,       22'd2,       22'd1,      22'd0,
      22'd0,       22'd0,       22'd0,      22'd0,
      22'd0,       22'd0,       22'd0,      22'd0
   };

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [Z_W-1:0]    z;
      logic                     on_axis;
      logic                     add_180;
      logic                     north;
      logic                     zero;
   } vpad_item_type;

endpackage

// ===== hw/rtl/vector_polar_angle_degrees_top.sv =====
// Top level of the pipelined CORDIC polar angle unit.
// Each transfer in brings one vector and a convention bit; exactly one result transfer
// comes out per input, in order, through one input stage, one register per CORDIC
// iteration and one output stage. A new vector is taken in every cycle; a stall
// on the result side only fills the empty stages, so input keeps flowing while any
// stage is free, and an empty output stage always accepts. The angle is in 1/65536
// degree, in [0, 360), counterclockwise from east (tuser 0) or clockwise from north
// (tuser 1); a zero vector gives angle 0 with the zero flag set.
module vector_polar_angle_degrees_top
   import vpad_pkg::*;
#(
   parameter int CORDIC_STAGES = 16,
   parameter int COORD_WIDTH   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // x_coord, y_coord, then zero padding to whole bytes
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]  req_tdata,
   // action
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // angle, then zero padding
   output logic [31:0]                         rsp_tdata,
   // zero_vector
   output logic                                rsp_tuser
);

   logic               valid [CORDIC_STAGES+1];
   logic               ready [CORDIC_STAGES+1];
   vpad_item_type      item  [CORDIC_STAGES+1];
   logic [ANGLE_W-1:0] angle;

   vpad_prep #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .action   (req_tuser),
      .x_coord  (req_tdata[COORD_WIDTH-1:0]),
      .y_coord  (req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .dn_valid (valid[0]),
      .dn_ready (ready[0]),
      .dn_item  (item[0])
   );

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
      vpad_stage #(
         .STAGE_IDX(k)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (valid[k]),
         .up_ready (ready[k]),
         .up_item  (item[k]),
         .dn_valid (valid[k+1]),
         .dn_ready (ready[k+1]),
         .dn_item  (item[k+1])
      );
   end

   vpad_finish u_finish (
      .clock       (clock),
      .reset       (reset),
      .up_valid    (valid[CORDIC_STAGES]),
      .up_ready    (ready[CORDIC_STAGES]),
      .up_item     (item[CORDIC_STAGES]),
      .dn_valid    (rsp_tvalid),
      .dn_ready    (rsp_tready),
      .angle       (angle),
      .zero_vector (rsp_tuser)
   );

   assign rsp_tdata = {{(32-ANGLE_W){1'b0}}, angle};

endmodule

// ===== hw/rtl/vpad_prep.sv =====
// Input stage: classifies the vector, folds the left half plane and scales up.
module vpad_prep
   import vpad_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  logic                          action,
   input  logic signed [COORD_WIDTH-1:0] x_coord,
   input  logic signed [COORD_WIDTH-1:0] y_coord,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output vpad_item_type                 dn_item
);

   localparam int GUARD = 60 - COORD_WIDTH;

   logic                     valid_ff;
   vpad_item_type            item_ff;
   vpad_item_type            item_in;
   logic signed [DATA_W-1:0] x_ext;
   logic signed [DATA_W-1:0] y_ext;
   logic                     x_zero;
   logic                     y_zero;
   logic                     x_neg;

   always_comb begin
      x_ext  = DATA_W'(x_coord);
      y_ext  = DATA_W'(y_coord);
      x_zero = (x_coord == '0);
      y_zero = (y_coord == '0);
      x_neg  = x_coord[COORD_WIDTH-1];

      item_in.north   = action;
      item_in.zero    = x_zero && y_zero;
      item_in.on_axis = x_zero || y_zero;
      item_in.add_180 = 1'b0;
      item_in.z       = '0;
      if (y_zero) begin
         item_in.z = x_neg ? DEG_180 : '0;
      end else if (x_zero) begin
         item_in.z = y_coord[COORD_WIDTH-1] ? DEG_270 : DEG_90;
      end else begin
         item_in.add_180 = x_neg;
      end

      // Turning by 180 degrees puts the vector in the right half plane.
      if (x_neg) begin
         item_in.x = (-x_ext) <<< GUARD;
         item_in.y = (-y_ext) <<< GUARD;
      end else begin
         item_in.x = x_ext <<< GUARD;
         item_in.y = y_ext <<< GUARD;
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         item_ff <= item_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;

endmodule

// ===== hw/rtl/vpad_stage.sv =====
// One vectoring iteration of the CORDIC pipeline, with its own register.
module vpad_stage
   import vpad_pkg::*;
#(
   parameter int STAGE_IDX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   output logic          up_ready,
   input  vpad_item_type up_item,
   output logic          dn_valid,
   input  logic          dn_ready,
   output vpad_item_type dn_item
);

   localparam logic signed [Z_W-1:0] ATAN_STEP = Z_W'(ATAN_TABLE[STAGE_IDX]);

   logic                     valid_ff;
   vpad_item_type            item_ff;
   vpad_item_type            item_in;
   logic signed [DATA_W-1:0] x_cur;
   logic signed [DATA_W-1:0] y_cur;
   logic signed [DATA_W-1:0] x_sh;
   logic signed [DATA_W-1:0] y_sh;

   always_comb begin
      x_cur   = up_item.x;
      y_cur   = up_item.y;
      x_sh    = x_cur >>> STAGE_IDX;
      y_sh    = y_cur >>> STAGE_IDX;
      item_in = up_item;
      if (!y_cur[DATA_W-1]) begin
         item_in.x = x_cur + y_sh;
         item_in.y = y_cur - x_sh;
      end else begin
         item_in.x = x_cur - y_sh;
         item_in.y = y_cur + x_sh;
      end
      // Axis vectors already carry their exact angle.
      if (!up_item.on_axis) begin
         item_in.z = y_cur[DATA_W-1] ? up_item.z - ATAN_STEP : up_item.z + ATAN_STEP;
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         item_ff <= item_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;

endmodule

// ===== hw/rtl/vpad_finish.sv =====
// Output stage: wraps the angle into one turn and, for the north convention, converts to a bearing.
module vpad_finish
   import vpad_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  vpad_item_type      up_item,
   output logic               dn_valid,
   input  logic               dn_ready,
   output logic [ANGLE_W-1:0] angle,
   output logic               zero_vector
);

   logic                  valid_ff;
   logic [ANGLE_W-1:0]    angle_ff;
   logic                  zero_ff;
   logic [ANGLE_W-1:0]    angle_in;
   logic signed [Z_W-1:0] east_sum;
   logic signed [Z_W-1:0] east;
   logic signed [Z_W-1:0] bearing;

   always_comb begin
      east_sum = up_item.add_180 ? up_item.z + DEG_180 : up_item.z;
      if (east_sum[Z_W-1]) begin
         east = east_sum + DEG_FULL;
      end else if (east_sum >= DEG_FULL) begin
         east = east_sum - DEG_FULL;
      end else begin
         east = east_sum;
      end
      bearing = DEG_90 - east;
      if (bearing[Z_W-1]) begin
         bearing = bearing + DEG_FULL;
      end
      if (up_item.zero) begin
         angle_in = '0;
      end else if (up_item.north) begin
         angle_in = bearing[ANGLE_W-1:0];
      end else begin
         angle_in = east[ANGLE_W-1:0];
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         angle_ff <= angle_in;
         zero_ff  <= up_item.zero;
      end
   end

   assign dn_valid    = valid_ff;
   assign angle       = angle_ff;
   assign zero_vector = zero_ff;

endmodule

// ===== hw/rtl/vpad_checker.sv =====
// Port-level checks of the polar angle unit, bound to its top level.
module vpad_checker
   import vpad_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A result that is not taken stays as it is.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // A zero vector has no direction, so its angle reads as zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("zero vector with nonzero angle");

   // Every angle lies within one turn.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata < 32'(DEG_FULL))
      else $error("angle out of range");

   // With the output stage empty, every stage behind it can move.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked while output empty");

endmodule

bind vector_polar_angle_degrees_top vpad_checker u_vpad_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== verif/vpad_checker.sv =====
`timescale 1ns / 100ps
// Checker for the polar angle unit: predicts each vector's angle and compares the results.
module vpad_tb_checker
   import vpad_pkg::*;
#(
   parameter int CORDIC_STAGES = 16,
   parameter int COORD_WIDTH   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   // x_coord, y_coord, then zero padding to whole bytes
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]  req_tdata,
   // action
   input  logic                                req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // angle, then zero padding
   input  logic [31:0]                         rsp_tdata,
   // zero_vector
   input  logic                                rsp_tuser,
   output int                                  fail_count,
   output int                                  pending
);

   localparam longint ONE_DEG     = 65536;
   localparam longint DEG_QUARTER = 90 * ONE_DEG;
   localparam longint DEG_HALF    = 180 * ONE_DEG;
   localparam longint DEG_CIRCLE  = 360 * ONE_DEG;
   localparam int     GUARD       = 60 - COORD_WIDTH;

   // atan(2^-i) in 1/65536 degree.
   localparam longint ATAN_DEG [32] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0,
      0, 0, 0, 0, 0, 0, 0, 0
   };

   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic               zero_vector;
   } bearing_type;

   bearing_type bearing_q [$];

   function automatic longint wrap_circle(longint a);
      longint r;
      r = a % DEG_CIRCLE;
      if (r < 0) begin
         r = r + DEG_CIRCLE;
      end
      return r;
   endfunction

   function automatic bearing_type polar_angle(logic north,
                                               logic signed [COORD_WIDTH-1:0] xc,
                                               logic signed [COORD_WIDTH-1:0] yc);
      longint x, y, z, xs, ys, a;
      bearing_type r;
      x = xc;
      y = yc;
      z = 0;
      r.zero_vector = 1'b0;
      if (x == 0 && y == 0) begin
         r.angle = '0;
         r.zero_vector = 1'b1;
         return r;
      end
      if (y == 0) begin
         a = (x > 0) ? 0 : DEG_HALF;
      end else if (x == 0) begin
         a = (y > 0) ? DEG_QUARTER : 3 * DEG_QUARTER;
      end else begin
         // Left half plane: turn the vector by a half circle first.
         if (x < 0) begin
            x = -x;
            y = -y;
            z = DEG_HALF;
         end
         x = x <<< GUARD;
         y = y <<< GUARD;
         for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               z = z + ATAN_DEG[i];
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - ATAN_DEG[i];
            end
         end
         a = z;
      end
      a = wrap_circle(a);
      if (north) begin
         a = wrap_circle(DEG_QUARTER - a);
      end
      r.angle = ANGLE_W'(a);
      return r;
   endfunction

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      bearing_type want;
      if (!reset) begin
         // Results are matched before new vectors are queued: a vector's result never leaves in the cycle it enters.
         if (rsp_tvalid && rsp_tready) begin
            if (bearing_q.size() == 0) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10) begin
                  $display("unexpected result: angle %0d zero %0b",
                           rsp_tdata[ANGLE_W-1:0], rsp_tuser);
               end
            end else begin
               want = bearing_q.pop_front();
               if (rsp_tdata[ANGLE_W-1:0] !== want.angle || rsp_tuser !== want.zero_vector) begin
                  fail_count = fail_count + 1;
                  if (fail_count <= 10) begin
                     $display("mismatch: expected angle %0d zero %0b, got angle %0d zero %0b",
                              want.angle, want.zero_vector,
                              rsp_tdata[ANGLE_W-1:0], rsp_tuser);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            bearing_q.push_back(polar_angle(req_tuser,
                                            req_tdata[COORD_WIDTH-1:0],
                                            req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]));
         end
         pending = bearing_q.size();
      end
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench top: drives vectors into the polar angle unit and reports the verdict.
module tb;

   localparam int COORD_W     = 32;
   localparam int HOLD_CYCLES = 80;
   localparam int RANDOM_ITEMS = 650;

   typedef enum logic {EAST_CCW, NORTH_CW} convention_type;

   // Directed vectors: zero, each axis, extremes, diagonals and the left half plane.
   localparam logic [COORD_W-1:0] DIR_X [13] = '{
      32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
      32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001
   };
   localparam logic [COORD_W-1:0] DIR_Y [13] = '{
      32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_0000,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF,
      32'h0001_0000, 32'h0000_8000, 32'h7FFF_FFFF
   };

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [2*COORD_W-1:0]   req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [31:0]            rsp_tdata;
   logic                   rsp_tuser;

   int   fail_count;
   int   pending;
   int   tx_idle_pct;
   int   rx_idle_pct;
   logic stall_wanted;
   logic stall_taken;

   vector_polar_angle_degrees_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   vpad_tb_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #10ms;
      $display("status: fail");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off that backs up the pipeline.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_wanted && !stall_taken) begin
            stall_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
      end
   end

   task automatic send_vector(input convention_type conv, input logic [COORD_W-1:0] xv,
                              input logic [COORD_W-1:0] yv);
      while ($urandom_range(99, 0) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {yv, xv};
      req_tuser  <= conv;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(9, 0))
         0: return '0;
         1: return COORD_W'($urandom_range(32, 0) - 32'd16);
         2: begin
            case ($urandom_range(3, 0))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'hFFFF_FFFF;
               default: return 32'h0000_0001;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   task automatic send_random(input int count);
      for (int n = 0; n < count; n++) begin
         send_vector(convention_type'($urandom_range(1, 0)), pick_coord(), pick_coord());
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      stall_wanted = 1'b0;
      stall_taken  = 1'b0;
      tx_idle_pct  = 19;
      rx_idle_pct  = 84;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 13; i++) begin
         send_vector(EAST_CCW, DIR_X[i], DIR_Y[i]);
         send_vector(NORTH_CW, DIR_X[i], DIR_Y[i]);
      end
      send_random(RANDOM_ITEMS / 3);

      tx_idle_pct = 84;
      rx_idle_pct = 19;
      send_random(RANDOM_ITEMS / 3);

      // No idling on either side; the long hold-off lands while vectors keep coming.
      tx_idle_pct  = 0;
      rx_idle_pct  = 0;
      stall_wanted = 1'b1;
      send_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
      req_tvalid <= 1'b0;

      wait (pending == 0);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
